// ===== rtl/snl_pkg.sv =====
// Shared types, constants and helpers for the pixel static nonlinearity.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package snl_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int LOG_FRAC  = 24;
    localparam int EXP_TERMS = 14;
    localparam int DIV_STEPS = 32;
    localparam int Z_W       = FRAC_BITS + 8;
    localparam int LG_W      = 6 + LOG_FRAC;
    localparam int NUM_W     = DATA_W + FRAC_BITS;
    localparam int EX_W      = 63;

    localparam logic [29:0]        LN2_Q30   = 30'd744261118;
    localparam logic signed [31:0] LOG2E_Q30 = 32'sd1549082005;

    // Reciprocals floor(2^32 / n) for the series divisors n = 1 .. 14.
    localparam logic [32:0] RECIP [1:EXP_TERMS] = '{
        33'((64'd1 << 32) / 1),  33'((64'd1 << 32) / 2),  33'((64'd1 << 32) / 3),
        33'((64'd1 << 32) / 4),  33'((64'd1 << 32) / 5),  33'((64'd1 << 32) / 6),
        33'((64'd1 << 32) / 7),  33'((64'd1 << 32) / 8),  33'((64'd1 << 32) / 9),
        33'((64'd1 << 32) / 10), 33'((64'd1 << 32) / 11), 33'((64'd1 << 32) / 12),
        33'((64'd1 << 32) / 13), 33'((64'd1 << 32) / 14)
    };

    typedef enum logic [1:0] {
        MODE_POLY = 2'd0,
        MODE_PASS = 2'd1,
        MODE_SYM  = 2'd2,
        MODE_STD  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        REG_MODE   = 3'd0,
        REG_CLAMP  = 3'd1,
        REG_LEVEL  = 3'd2,
        REG_SLOPE  = 3'd3,
        REG_BIAS   = 3'd4,
        REG_POWER  = 3'd5
    } reg_idx_t;

    typedef struct packed {
        mode_t              mode;
        logic               clamp_en;
        logic signed [31:0] clamp_level;
        logic signed [31:0] slope;
        logic signed [31:0] bias;
        logic signed [31:0] power;
    } cfg_t;

    // Per-beat sideband that travels down the pipeline with the data.
    typedef struct packed {
        logic              force_en;
        logic [DATA_W-1:0] force_val;
        logic              inv;
        logic              neg;
    } side_t;

    function automatic logic [DATA_W-1:0] sat32(input logic [65:0] v);
        logic signed [65:0] sv;
        sv = $signed(v);
        if (sv > 66'sd2147483647)
        begin
            return 32'h7FFF_FFFF;
        end
        if (sv < -66'sd2147483648)
        begin
            return 32'h8000_0000;
        end
        return sv[31:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/snl_front.sv =====
// Front end: clamp and slope multiply, base or sigmoid exponent, log2 normalise.
// Depends on snl_pkg.
`default_nettype none

module snl_front (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   advance,
    input  wire snl_pkg::cfg_t          cfg,
    input  wire logic                   in_valid,
    input  wire logic signed [31:0]     pixel_in,
    output logic                        out_valid,
    output logic [31:0]                 out_m,
    output logic [4:0]                  out_k,
    output logic signed [snl_pkg::Z_W-1:0] out_z,
    output snl_pkg::side_t              out_side
);
    import snl_pkg::*;

    localparam logic signed [65:0] Z_LIM = 66'sd64 <<< FRAC_BITS;

    // Stage 1: clamp, operand select and multiply.
    logic signed [31:0] xc;
    logic signed [32:0] v;
    logic signed [64:0] s1_prod_next;
    logic signed [64:0] s1_prod_reg;
    logic signed [31:0] s1_x_reg;
    logic               s1_valid_reg;

    always_comb
    begin
        xc = pixel_in;
        if (cfg.mode == MODE_POLY && cfg.clamp_en && pixel_in < cfg.clamp_level)
        begin
            xc = cfg.clamp_level;
        end
        if (cfg.mode == MODE_SYM && pixel_in[31])
        begin
            v = -33'(pixel_in);
        end
        else
        begin
            v = 33'(xc);
        end
        s1_prod_next = 65'(v) * 65'(cfg.slope);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_prod_reg <= s1_prod_next;
            s1_x_reg    <= pixel_in;
        end
    end

    // Stage 2: floor shift, saturating base, sigmoid exponent and special cases.
    logic signed [64:0]    sh;
    logic [31:0]           bm;
    logic signed [65:0]    bsum;
    logic signed [31:0]    b_next;
    logic signed [65:0]    zw;
    logic signed [Z_W-1:0] s2_z_next;
    logic [31:0]           s2_mag_next;
    side_t                 s2_side_next;
    logic [31:0]           s2_mag_reg;
    logic signed [Z_W-1:0] s2_z_reg;
    side_t                 s2_side_reg;
    logic                  s2_valid_reg;

    always_comb
    begin
        sh     = s1_prod_reg >>> FRAC_BITS;
        bm     = sat32(66'(sh));
        bsum   = 66'($signed(bm)) + 66'(cfg.bias);
        b_next = $signed(sat32(bsum));
        zw     = 66'(cfg.bias) - 66'(sh);
        if (zw > Z_LIM)
        begin
            zw = Z_LIM;
        end
        else if (zw < -Z_LIM)
        begin
            zw = -Z_LIM;
        end
        s2_z_next   = Z_W'(zw);
        s2_mag_next = b_next[31] ? (~b_next + 32'd1) : b_next;

        s2_side_next = '0;
        unique case (cfg.mode)
            MODE_POLY:
            begin
                s2_side_next.neg = b_next[31] & cfg.power[FRAC_BITS];
                if (cfg.power == 32'sd0)
                begin
                    s2_side_next.force_en  = 1'b1;
                    s2_side_next.force_val = 32'd1 << FRAC_BITS;
                end
                else if (b_next == 32'sd0)
                begin
                    s2_side_next.force_en = 1'b1;
                    s2_side_next.inv      = cfg.power[31];
                end
                else if (b_next[31] && (|cfg.power[FRAC_BITS-1:0]))
                begin
                    s2_side_next.force_en = 1'b1;
                    s2_side_next.inv      = 1'b1;
                end
            end
            MODE_PASS:
            begin
                s2_side_next.force_en  = 1'b1;
                s2_side_next.force_val = s1_x_reg;
            end
            MODE_SYM:
            begin
                s2_side_next.neg = s1_x_reg[31] ^ cfg.power[31];
                if (s1_x_reg == 32'sd0)
                begin
                    s2_side_next.force_en = 1'b1;
                end
            end
            MODE_STD:
            begin
                s2_side_next.neg = cfg.power[31];
            end
            default:
            begin
                s2_side_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_mag_reg  <= s2_mag_next;
            s2_z_reg    <= s2_z_next;
            s2_side_reg <= s2_side_next;
        end
    end

    // Stage 3: leading-one position and mantissa normalisation.
    logic [4:0]  s3_k_next;
    logic [31:0] s3_m_next;
    logic [4:0]  s3_k_reg;
    logic [31:0] s3_m_reg;
    logic signed [Z_W-1:0] s3_z_reg;
    side_t       s3_side_reg;
    logic        s3_valid_reg;

    always_comb
    begin
        s3_k_next = 5'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (s2_mag_reg[i])
            begin
                s3_k_next = 5'(i);
            end
        end
        s3_m_next = s2_mag_reg << (5'd31 - s3_k_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s3_k_reg    <= s3_k_next;
            s3_m_reg    <= s3_m_next;
            s3_z_reg    <= s2_z_reg;
            s3_side_reg <= s2_side_reg;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_m     = s3_m_reg;
    assign out_k     = s3_k_reg;
    assign out_z     = s3_z_reg;
    assign out_side  = s3_side_reg;

endmodule

`default_nettype wire

// ===== rtl/snl_log2.sv =====
// Fractional log2 by repeated squaring, one squaring round per pipeline stage.
// Depends on snl_pkg.
`default_nettype none

module snl_log2 (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       advance,
    input  wire logic                       in_valid,
    input  wire logic [31:0]                in_m,
    input  wire logic [4:0]                 in_k,
    input  wire logic signed [snl_pkg::Z_W-1:0] in_z,
    input  wire snl_pkg::side_t             in_side,
    output logic                            out_valid,
    output logic signed [snl_pkg::LG_W-1:0] out_lg,
    output logic signed [snl_pkg::Z_W-1:0]  out_z,
    output snl_pkg::side_t                  out_side
);
    import snl_pkg::*;

    logic [31:0]           m_reg    [LOG_FRAC];
    logic [LOG_FRAC-1:0]   fr_reg   [LOG_FRAC];
    logic [4:0]            k_reg    [LOG_FRAC];
    logic signed [Z_W-1:0] z_reg    [LOG_FRAC];
    side_t                 side_reg [LOG_FRAC];
    logic                  v_reg    [LOG_FRAC];

    for (genvar g = 0; g < LOG_FRAC; g++)
    begin : g_round
        logic [31:0]           m_in;
        logic [LOG_FRAC-1:0]   fr_in;
        logic [4:0]            k_in;
        logic signed [Z_W-1:0] z_in;
        side_t                 side_in;
        logic                  v_in;
        logic [63:0]           sq;
        logic [32:0]           r;

        if (g == 0)
        begin : g_first
            assign m_in    = in_m;
            assign fr_in   = '0;
            assign k_in    = in_k;
            assign z_in    = in_z;
            assign side_in = in_side;
            assign v_in    = in_valid;
        end
        else
        begin : g_rest
            assign m_in    = m_reg[g-1];
            assign fr_in   = fr_reg[g-1];
            assign k_in    = k_reg[g-1];
            assign z_in    = z_reg[g-1];
            assign side_in = side_reg[g-1];
            assign v_in    = v_reg[g-1];
        end

        assign sq = 64'(m_in) * 64'(m_in);
        assign r  = sq[63:31];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[g] <= 1'b0;
            end
            else if (advance)
            begin
                v_reg[g] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                m_reg[g]    <= r[32] ? r[32:1] : r[31:0];
                fr_reg[g]   <= {fr_in[LOG_FRAC-2:0], r[32]};
                k_reg[g]    <= k_in;
                z_reg[g]    <= z_in;
                side_reg[g] <= side_in;
            end
        end
    end

    logic [5:0] kf;
    assign kf        = 6'({1'b0, k_reg[LOG_FRAC-1]}) - 6'(FRAC_BITS);
    assign out_lg    = $signed({kf, fr_reg[LOG_FRAC-1]});
    assign out_valid = v_reg[LOG_FRAC-1];
    assign out_z     = z_reg[LOG_FRAC-1];
    assign out_side  = side_reg[LOG_FRAC-1];

endmodule

`default_nettype wire

// ===== rtl/snl_exp2.sv =====
// Exponent scaling and pipelined exp2: a Taylor series of truncated terms, three stages
// per term, then the final power-of-two shift. Depends on snl_pkg.
`default_nettype none

module snl_exp2 (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       advance,
    input  wire snl_pkg::cfg_t              cfg,
    input  wire logic                       in_valid,
    input  wire logic signed [snl_pkg::LG_W-1:0] in_lg,
    input  wire logic signed [snl_pkg::Z_W-1:0]  in_z,
    input  wire snl_pkg::side_t             in_side,
    output logic                            out_valid,
    output logic [snl_pkg::EX_W-1:0]        out_ex,
    output snl_pkg::side_t                  out_side
);
    import snl_pkg::*;

    localparam int EXP_SHIFT = 30 + FRAC_BITS - LOG_FRAC;

    // Stage A: exponent product, log2 times power or z times log2(e).
    logic signed [31:0] a_op;
    logic signed [31:0] b_op;
    logic signed [63:0] pa_next;
    logic signed [63:0] pa_reg;
    side_t              sa_side_reg;
    logic               sa_valid_reg;

    always_comb
    begin
        if (cfg.mode == MODE_POLY)
        begin
            a_op = 32'(in_lg);
            b_op = cfg.power;
        end
        else
        begin
            a_op = 32'(in_z);
            b_op = LOG2E_Q30;
        end
        pa_next = 64'(a_op) * 64'(b_op);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sa_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            sa_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pa_reg      <= pa_next;
            sa_side_reg <= in_side;
        end
    end

    // Stage B: split into integer and fraction, scale the fraction by ln2.
    logic signed [63:0]   e;
    logic signed [63:0]   ei;
    logic [LOG_FRAC-1:0]  fr;
    logic [LOG_FRAC+29:0] tp;
    logic [29:0]          t_next;
    logic signed [39:0]   s_next;
    logic [29:0]          sb_t_reg;
    logic signed [39:0]   sb_s_reg;
    side_t                sb_side_reg;
    logic                 sb_valid_reg;

    always_comb
    begin
        if (cfg.mode == MODE_POLY)
        begin
            e = pa_reg >>> FRAC_BITS;
        end
        else
        begin
            e = pa_reg >>> EXP_SHIFT;
        end
        ei     = e >>> LOG_FRAC;
        fr     = e[LOG_FRAC-1:0];
        s_next = 40'(ei) + 40'(FRAC_BITS - 30);
        tp     = (LOG_FRAC+30)'(fr) * (LOG_FRAC+30)'(LN2_Q30);
        t_next = tp[LOG_FRAC +: 30];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sb_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            sb_valid_reg <= sa_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sb_t_reg    <= t_next;
            sb_s_reg    <= s_next;
            sb_side_reg <= sa_side_reg;
        end
    end

    // Series terms: multiply, reciprocal multiply, correct and accumulate.
    logic [30:0]        pm_reg    [EXP_TERMS];
    logic [31:0]        suma_reg  [EXP_TERMS];
    logic [29:0]        ta_reg    [EXP_TERMS];
    logic signed [39:0] xa_reg    [EXP_TERMS];
    side_t              sdb_reg   [EXP_TERMS];
    logic               va_reg    [EXP_TERMS];

    logic [30:0]        pq_reg    [EXP_TERMS];
    logic [30:0]        est_reg   [EXP_TERMS];
    logic [31:0]        sumb_reg  [EXP_TERMS];
    logic [29:0]        tb_reg    [EXP_TERMS];
    logic signed [39:0] xb_reg    [EXP_TERMS];
    side_t              sdc_reg   [EXP_TERMS];
    logic               vb_reg    [EXP_TERMS];

    logic [30:0]        term_reg  [EXP_TERMS];
    logic [31:0]        sum_reg   [EXP_TERMS];
    logic [29:0]        tc_reg    [EXP_TERMS];
    logic signed [39:0] xc_reg    [EXP_TERMS];
    side_t              sdd_reg   [EXP_TERMS];
    logic               vc_reg    [EXP_TERMS];

    for (genvar g = 0; g < EXP_TERMS; g++)
    begin : g_term
        logic [30:0]        term_in;
        logic [31:0]        sum_in;
        logic [29:0]        t_in;
        logic signed [39:0] s_in;
        side_t              side_in;
        logic               v_in;
        logic [60:0]        pprod;
        logic [63:0]        rprod;
        logic [34:0]        back;
        logic [34:0]        rem;
        logic [30:0]        term_next;

        if (g == 0)
        begin : g_first
            assign term_in = 31'd1 << 30;
            assign sum_in  = 32'd1 << 30;
            assign t_in    = sb_t_reg;
            assign s_in    = sb_s_reg;
            assign side_in = sb_side_reg;
            assign v_in    = sb_valid_reg;
        end
        else
        begin : g_rest
            assign term_in = term_reg[g-1];
            assign sum_in  = sum_reg[g-1];
            assign t_in    = tc_reg[g-1];
            assign s_in    = xc_reg[g-1];
            assign side_in = sdd_reg[g-1];
            assign v_in    = vc_reg[g-1];
        end

        assign pprod     = 61'(term_in) * 61'(t_in);
        assign rprod     = 64'(pm_reg[g]) * 64'(RECIP[g+1]);
        assign back      = 35'(est_reg[g]) * 35'(g + 1);
        assign rem       = 35'(pq_reg[g]) - back;
        assign term_next = (rem >= 35'(g + 1)) ? est_reg[g] + 31'd1 : est_reg[g];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                va_reg[g] <= 1'b0;
                vb_reg[g] <= 1'b0;
                vc_reg[g] <= 1'b0;
            end
            else if (advance)
            begin
                va_reg[g] <= v_in;
                vb_reg[g] <= va_reg[g];
                vc_reg[g] <= vb_reg[g];
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                pm_reg[g]   <= pprod[60:30];
                suma_reg[g] <= sum_in;
                ta_reg[g]   <= t_in;
                xa_reg[g]   <= s_in;
                sdb_reg[g]  <= side_in;

                pq_reg[g]   <= pm_reg[g];
                est_reg[g]  <= rprod[62:32];
                sumb_reg[g] <= suma_reg[g];
                tb_reg[g]   <= ta_reg[g];
                xb_reg[g]   <= xa_reg[g];
                sdc_reg[g]  <= sdb_reg[g];

                term_reg[g] <= term_next;
                sum_reg[g]  <= sumb_reg[g] + 32'(term_next);
                tc_reg[g]   <= tb_reg[g];
                xc_reg[g]   <= xb_reg[g];
                sdd_reg[g]  <= sdc_reg[g];
            end
        end
    end

    // Final stage: scale the series sum by the integer part of the exponent.
    logic signed [39:0] s_fin;
    logic [39:0]        s_neg;
    logic [EX_W-1:0]    ex_next;
    logic [EX_W-1:0]    ex_reg;
    side_t              ex_side_reg;
    logic               ex_valid_reg;

    always_comb
    begin
        s_fin = xc_reg[EXP_TERMS-1];
        s_neg = -s_fin;
        priority if (s_fin > 40'sd31)
        begin
            ex_next = EX_W'(1) << 62;
        end
        else if (s_fin >= 40'sd0)
        begin
            ex_next = EX_W'(sum_reg[EXP_TERMS-1]) << s_fin[4:0];
        end
        else if (s_fin <= -40'sd64)
        begin
            ex_next = '0;
        end
        else
        begin
            ex_next = EX_W'(sum_reg[EXP_TERMS-1]) >> s_neg[5:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ex_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            ex_valid_reg <= vc_reg[EXP_TERMS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ex_reg      <= ex_next;
            ex_side_reg <= sdd_reg[EXP_TERMS-1];
        end
    end

    assign out_valid = ex_valid_reg;
    assign out_ex    = ex_reg;
    assign out_side  = ex_side_reg;

endmodule

`default_nettype wire

// ===== rtl/snl_div.sv =====
// Polynomial result saturation and the sigmoid quotient |gain|*2^F / (2^F + exp),
// one restoring division step per pipeline stage. Depends on snl_pkg.
`default_nettype none

module snl_div (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                advance,
    input  wire snl_pkg::cfg_t       cfg,
    input  wire logic                in_valid,
    input  wire logic [snl_pkg::EX_W-1:0] in_ex,
    input  wire snl_pkg::side_t      in_side,
    output logic                     out_valid,
    output logic [31:0]              out_q,
    output snl_pkg::side_t           out_side
);
    import snl_pkg::*;

    // Preparation stage.
    logic [31:0]      gain_mag;
    logic [NUM_W-1:0] num_next;
    logic [63:0]      d_next;
    side_t            side_next;
    logic [NUM_W-1:0] num_reg;
    logic [63:0]      d_reg;
    logic [62:0]      rem0_reg;
    side_t            p_side_reg;
    logic             p_valid_reg;

    always_comb
    begin
        gain_mag  = cfg.power[31] ? (~cfg.power + 32'd1) : cfg.power;
        num_next  = NUM_W'(gain_mag) << FRAC_BITS;
        d_next    = 64'(in_ex) + (64'd1 << FRAC_BITS);
        side_next = in_side;
        if (cfg.mode == MODE_POLY && !in_side.force_en)
        begin
            side_next.force_en  = 1'b1;
            side_next.force_val = sat32(in_side.neg ? -66'(in_ex) : 66'(in_ex));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            p_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            num_reg    <= num_next;
            d_reg      <= d_next;
            rem0_reg   <= 63'(num_next >> DIV_STEPS);
            p_side_reg <= side_next;
        end
    end

    logic [NUM_W-1:0] n_reg    [DIV_STEPS];
    logic [63:0]      dd_reg   [DIV_STEPS];
    logic [62:0]      rem_reg  [DIV_STEPS];
    logic [31:0]      q_reg    [DIV_STEPS];
    side_t            side_reg [DIV_STEPS];
    logic             v_reg    [DIV_STEPS];

    for (genvar g = 0; g < DIV_STEPS; g++)
    begin : g_step
        logic [NUM_W-1:0] n_in;
        logic [63:0]      d_in;
        logic [62:0]      rem_in;
        logic [31:0]      q_in;
        side_t            side_in;
        logic             v_in;
        logic [63:0]      rem_t;
        logic             take;

        if (g == 0)
        begin : g_first
            assign n_in    = num_reg;
            assign d_in    = d_reg;
            assign rem_in  = rem0_reg;
            assign q_in    = '0;
            assign side_in = p_side_reg;
            assign v_in    = p_valid_reg;
        end
        else
        begin : g_rest
            assign n_in    = n_reg[g-1];
            assign d_in    = dd_reg[g-1];
            assign rem_in  = rem_reg[g-1];
            assign q_in    = q_reg[g-1];
            assign side_in = side_reg[g-1];
            assign v_in    = v_reg[g-1];
        end

        assign rem_t = {rem_in, n_in[DIV_STEPS-1-g]};
        assign take  = rem_t >= d_in;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[g] <= 1'b0;
            end
            else if (advance)
            begin
                v_reg[g] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                n_reg[g]    <= n_in;
                dd_reg[g]   <= d_in;
                rem_reg[g]  <= take ? 63'(rem_t - d_in) : rem_t[62:0];
                q_reg[g]    <= {q_in[30:0], take};
                side_reg[g] <= side_in;
            end
        end
    end

    assign out_valid = v_reg[DIV_STEPS-1];
    assign out_q     = q_reg[DIV_STEPS-1];
    assign out_side  = side_reg[DIV_STEPS-1];

endmodule

`default_nettype wire

// ===== rtl/pixel_static_nonlinearity.sv =====
// Top level of the pixel static nonlinearity: configuration registers, pipeline control
// and the output register. Depends on snl_pkg, snl_front, snl_log2, snl_exp2 and snl_div.
//
// Usage. Pixels arrive on the source channel (src_valid, src_stall, pixel_in) and results
// leave on the destination channel (dst_valid, dst_stall, pixel_out, invalid). A beat
// moves at a rising edge where valid is high and stall is low. Every input beat gives
// exactly one output beat, in order.
// Throughput is one beat per cycle while the receiver does not stall. A beat passes
// through three front stages, 24 log2 squaring rounds, two exponent stages, three
// stages for each of the 14 series terms, one scaling shift, one preparation stage and
// 32 restoring division steps, then the output register. Every mode takes the same path.
// The whole pipeline moves as one: it advances whenever the output register is empty or
// its beat is being taken, so the next pixel is accepted in the same cycle that a waiting
// result leaves. While the receiver stalls a full output register, the pipeline holds
// and src_stall is raised; nothing is lost or repeated.
// Reset clears every valid bit and loads the registers with mode polynomial, clamp off,
// clamp level 0, slope 1.0, bias 0 and power 1.0. Registers are written through the APB
// port at byte address 4*index and should only change while the pipeline is empty.
`default_nettype none

module pixel_static_nonlinearity (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  wire logic               src_valid,
    output logic                    src_stall,
    input  wire logic signed [31:0] pixel_in,
    output logic                    dst_valid,
    input  wire logic               dst_stall,
    output logic signed [31:0]      pixel_out,
    output logic                    invalid
);
    import snl_pkg::*;

    // Configuration registers.
    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[4:2]);

    always_comb
    begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite)
        begin
            unique case (reg_idx)
                REG_MODE:  cfg_next.mode        = mode_t'(pwdata[1:0]);
                REG_CLAMP: cfg_next.clamp_en    = pwdata[0];
                REG_LEVEL: cfg_next.clamp_level = $signed(pwdata);
                REG_SLOPE: cfg_next.slope       = $signed(pwdata);
                REG_BIAS:  cfg_next.bias        = $signed(pwdata);
                REG_POWER: cfg_next.power       = $signed(pwdata);
                default:   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode        <= MODE_POLY;
            cfg_reg.clamp_en    <= 1'b0;
            cfg_reg.clamp_level <= '0;
            cfg_reg.slope       <= 32'sd1 <<< FRAC_BITS;
            cfg_reg.bias        <= '0;
            cfg_reg.power       <= 32'sd1 <<< FRAC_BITS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_MODE:  prdata = 32'(cfg_reg.mode);
            REG_CLAMP: prdata = 32'(cfg_reg.clamp_en);
            REG_LEVEL: prdata = cfg_reg.clamp_level;
            REG_SLOPE: prdata = cfg_reg.slope;
            REG_BIAS:  prdata = cfg_reg.bias;
            REG_POWER: prdata = cfg_reg.power;
            default:   prdata = '0;
        endcase
    end

    // Pipeline control: one advance signal for every stage.
    logic  advance;
    logic  out_valid_reg;

    assign advance   = !(out_valid_reg && dst_stall);
    assign src_stall = !advance;

    // Front end.
    logic                  f_valid;
    logic [31:0]           f_m;
    logic [4:0]            f_k;
    logic signed [Z_W-1:0] f_z;
    side_t                 f_side;

    snl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .cfg       (cfg_reg),
        .in_valid  (src_valid),
        .pixel_in  (pixel_in),
        .out_valid (f_valid),
        .out_m     (f_m),
        .out_k     (f_k),
        .out_z     (f_z),
        .out_side  (f_side)
    );

    // Logarithm.
    logic                   l_valid;
    logic signed [LG_W-1:0] l_lg;
    logic signed [Z_W-1:0]  l_z;
    side_t                  l_side;

    snl_log2 u_log2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (f_valid),
        .in_m      (f_m),
        .in_k      (f_k),
        .in_z      (f_z),
        .in_side   (f_side),
        .out_valid (l_valid),
        .out_lg    (l_lg),
        .out_z     (l_z),
        .out_side  (l_side)
    );

    // Exponential.
    logic            e_valid;
    logic [EX_W-1:0] e_ex;
    side_t           e_side;

    snl_exp2 u_exp2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .cfg       (cfg_reg),
        .in_valid  (l_valid),
        .in_lg     (l_lg),
        .in_z      (l_z),
        .in_side   (l_side),
        .out_valid (e_valid),
        .out_ex    (e_ex),
        .out_side  (e_side)
    );

    // Sigmoid division.
    logic        d_valid;
    logic [31:0] d_q;
    side_t       d_side;

    snl_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .cfg       (cfg_reg),
        .in_valid  (e_valid),
        .in_ex     (e_ex),
        .in_side   (e_side),
        .out_valid (d_valid),
        .out_q     (d_q),
        .out_side  (d_side)
    );

    // Output register: forced results win, otherwise the signed, saturated quotient.
    logic [31:0] pixel_next;
    logic [31:0] pixel_reg;
    logic        invalid_reg;

    always_comb
    begin
        if (d_side.force_en)
        begin
            pixel_next = d_side.force_val;
        end
        else
        begin
            pixel_next = sat32(d_side.neg ? -66'(d_q) : 66'(d_q));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= d_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pixel_reg   <= pixel_next;
            invalid_reg <= d_side.inv;
        end
    end

    assign dst_valid = out_valid_reg;
    assign pixel_out = $signed(pixel_reg);
    assign invalid   = invalid_reg;

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for pixel_static_nonlinearity: stimulus, APB set-up and a scoreboard.
// Depends on snl_pkg and the pixel_static_nonlinearity RTL only.
`timescale 1ns / 100ps

module tb;
    import snl_pkg::*;

    localparam int     HALF_PERIOD = 5;
    localparam int     WATCHDOG    = 5000;
    localparam int     DRAIN       = 120;
    localparam longint Q1          = 64'sd65536;

    // Scoreboard: holds the register copy, predicts each pixel and checks results in order.
    class snl_scoreboard;
        logic [1:0]         mode;
        logic               clamp_en;
        logic signed [31:0] level;
        logic signed [31:0] slope;
        logic signed [31:0] bias;
        logic signed [31:0] power;
        logic [32:0]        pending_q[$];
        int                 errors;

        function new();
            mode     = MODE_POLY;
            clamp_en = 1'b0;
            level    = 0;
            slope    = 32'sd65536;
            bias     = 0;
            power    = 32'sd65536;
            errors   = 0;
        endfunction

        function longint sat(longint v);
            if (v > 64'sd2147483647)
            begin
                return 64'sd2147483647;
            end
            if (v < -64'sd2147483648)
            begin
                return -64'sd2147483648;
            end
            return v;
        endfunction

        // log2 of a positive raw value, result with 24 fractional bits.
        function longint log2_q24(bit [63:0] u);
            int        k;
            bit [63:0] m;
            bit [63:0] fr;
            k  = 31;
            fr = '0;
            while (k > 0 && u[k] == 1'b0)
            begin
                k--;
            end
            m = u << (31 - k);
            for (int i = 0; i < LOG_FRAC; i++)
            begin
                m  = (m * m) >> 31;
                fr = fr << 1;
                if (m >= 64'h1_0000_0000)
                begin
                    fr = fr | 64'd1;
                    m  = m >> 1;
                end
            end
            return (longint'(k) - FRAC_BITS) * 64'sd16777216 + longint'(fr);
        endfunction

        // 2^e with e in 24 fractional bits; returns a raw Q16.16 magnitude capped at 2^62.
        function bit [63:0] exp2_raw(longint e);
            longint    ei;
            longint    s;
            bit [63:0] fr;
            bit [63:0] t;
            bit [63:0] term;
            bit [63:0] sum;
            ei   = e >>> LOG_FRAC;
            fr   = e - (ei * 64'sd16777216);
            t    = (fr * 64'(LN2_Q30)) >> LOG_FRAC;
            term = 64'd1 << 30;
            sum  = 64'd1 << 30;
            for (int n = 1; n <= EXP_TERMS; n++)
            begin
                term = ((term * t) >> 30) / 64'(n);
                sum  = sum + term;
            end
            s = ei + FRAC_BITS - 30;
            if (s > 31)
            begin
                return 64'd1 << 62;
            end
            if (s >= 0)
            begin
                return sum << s;
            end
            if (s <= -64)
            begin
                return '0;
            end
            return sum >> (-s);
        endfunction

        function longint logistic(longint v, longint sl, longint bs, longint gain);
            longint    z;
            longint    lim;
            longint    e;
            bit [63:0] d;
            bit [63:0] g;
            longint    q;
            lim = 64'sd64 <<< FRAC_BITS;
            z   = bs - ((v * sl) >>> FRAC_BITS);
            if (z > lim)
            begin
                z = lim;
            end
            if (z < -lim)
            begin
                z = -lim;
            end
            e = (z * 64'(LOG2E_Q30)) >>> (30 + FRAC_BITS - LOG_FRAC);
            d = (64'd1 << FRAC_BITS) + exp2_raw(e);
            g = (gain < 0) ? -gain : gain;
            q = longint'((g << FRAC_BITS) / d);
            return (gain < 0) ? -q : q;
        endfunction

        // Works out the result for one accepted pixel and queues it as {invalid, pixel_out}.
        function void note(logic signed [31:0] pix);
            longint    x;
            longint    b;
            longint    r;
            longint    res;
            bit [63:0] mag;
            logic      inv;
            logic [31:0] res32;
            x   = longint'(pix);
            res = x;
            inv = 1'b0;
            if (mode == MODE_POLY)
            begin
                if (clamp_en && x < longint'(level))
                begin
                    x = longint'(level);
                end
                b = sat((x * longint'(slope)) >>> FRAC_BITS);
                b = sat(b + longint'(bias));
                if (power == 0)
                begin
                    res = Q1;
                end
                else if (b == 0)
                begin
                    res = 0;
                    inv = (power < 0);
                end
                else if (b < 0 && power[FRAC_BITS-1:0] != 0)
                begin
                    res = 0;
                    inv = 1'b1;
                end
                else
                begin
                    mag = (b < 0) ? -b : b;
                    r   = longint'(exp2_raw((log2_q24(mag) * longint'(power)) >>> FRAC_BITS));
                    res = (b < 0 && power[FRAC_BITS]) ? -r : r;
                end
            end
            else if (mode == MODE_SYM)
            begin
                if (x == 0)
                begin
                    res = 0;
                end
                else
                begin
                    r   = logistic((x < 0) ? -x : x, longint'(slope), longint'(bias),
                                   longint'(power));
                    res = (x < 0) ? -r : r;
                end
            end
            else if (mode == MODE_STD)
            begin
                res = logistic(x, longint'(slope), longint'(bias), longint'(power));
            end
            res32 = 32'(sat(res));
            pending_q.push_back({inv, res32});
        endfunction

        function void check(logic signed [31:0] pix, logic inv);
            logic [32:0] exp_beat;
            if (pending_q.size() == 0)
            begin
                $display("%0t: unexpected result pixel_out=%h invalid=%b", $time, pix, inv);
                errors++;
                return;
            end
            exp_beat = pending_q.pop_front();
            if (pix !== exp_beat[31:0])
            begin
                $display("%0t: pixel_out expected %h actual %h", $time, exp_beat[31:0], pix);
                errors++;
            end
            if (inv !== exp_beat[32])
            begin
                $display("%0t: invalid expected %b actual %b", $time, exp_beat[32], inv);
                errors++;
            end
        endfunction
    endclass

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [4:0]         paddr     = '0;
    logic [31:0]        pwdata    = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               src_valid = 1'b0;
    logic               src_stall;
    logic signed [31:0] pixel_in  = '0;
    logic               dst_valid;
    logic               dst_stall = 1'b0;
    logic signed [31:0] pixel_out;
    logic               invalid;

    snl_scoreboard sb = new();
    bit            quiet;        // set for the closing stretch, where neither side idles
    int            stall_left;
    int            idle_cycles;
    int            beats_in;
    int            beats_out;
    int            phases;

    pixel_static_nonlinearity u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .pixel_in  (pixel_in),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .pixel_out (pixel_out),
        .invalid   (invalid)
    );

    always #HALF_PERIOD clk = ~clk;

    // Receiver: every beat taken is checked at once; stall comes in short random bursts.
    always @(posedge clk)
    begin
        if (rst_n && dst_valid && !dst_stall)
        begin
            sb.check(pixel_out, invalid);
            beats_out++;
        end
        if (quiet)
        begin
            dst_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            dst_stall <= 1'b1;
        end
        else if ($urandom_range(0, 6) == 0)
        begin
            stall_left = int'($urandom_range(0, 2));
            dst_stall <= 1'b1;
        end
        else
        begin
            dst_stall <= 1'b0;
        end
    end

    // Watchdog: any cycle with no beat on either channel and no register access counts.
    always @(posedge clk)
    begin
        if ((src_valid && !src_stall) || (dst_valid && !dst_stall) || psel || !rst_n)
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG)
        begin
            $display("%0t: watchdog expired with %0d results outstanding", $time,
                     sb.pending_q.size());
            $display("status: fail");
            $finish;
        end
    end

    // Offers one pixel, holds it until the block takes it, then maybe leaves a short gap.
    task automatic send_pixel(input logic signed [31:0] v);
        src_valid <= 1'b1;
        pixel_in  <= v;
        @(posedge clk);
        while (src_stall)
        begin
            @(posedge clk);
        end
        sb.note(v);
        beats_in++;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            src_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    task automatic apb_write(input reg_idx_t idx, input logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Drains the pipeline, then rewrites every register and the scoreboard's copy of them.
    task automatic configure(input logic [1:0] m, input logic ce, input logic [31:0] lvl,
                             input logic [31:0] sl, input logic [31:0] bs,
                             input logic [31:0] pw);
        src_valid <= 1'b0;
        while (sb.pending_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
        apb_write(REG_MODE, {30'd0, m});
        apb_write(REG_CLAMP, {31'd0, ce});
        apb_write(REG_LEVEL, lvl);
        apb_write(REG_SLOPE, sl);
        apb_write(REG_BIAS, bs);
        apb_write(REG_POWER, pw);
        sb.mode     = m;
        sb.clamp_en = ce;
        sb.level    = lvl;
        sb.slope    = sl;
        sb.bias     = bs;
        sb.power    = pw;
        phases++;
    endtask

    // A Q16.16 value that is small most of the time, full range or an extreme otherwise.
    function automatic logic [31:0] rand_q(input int span);
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0:       v = $urandom;
            1:       v = ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
            2:       v = '0;
            default: v = $urandom_range(0, 2 * span) - span;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] rand_power();
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0:       v = '0;
            1:       v = $urandom;
            2:       v = $urandom_range(0, 8 << 16) - (4 << 16);
            default: v = ($urandom_range(0, 8) - 3) << 16;
        endcase
        return v;
    endfunction

    initial
    begin
        quiet      = 1'b0;
        stall_left = 0;
        idle_cycles = 0;
        beats_in   = 0;
        beats_out  = 0;
        phases     = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset settings: identity power law, with the input extremes.
        send_pixel(32'sd0);
        send_pixel(32'h7FFF_FFFF);
        send_pixel(32'h8000_0000);
        send_pixel(32'sd65536);
        send_pixel(-32'sd65536);

        // Clamp below -1.0, slope 2.0, bias 0.5, squared.
        configure(MODE_POLY, 1'b1, -32'sd65536, 32'sd131072, 32'sd32768, 32'sd131072);
        send_pixel(-32'sd327680);
        send_pixel(32'sd196608);
        send_pixel(32'h8000_0000);

        // Odd integer power on a negative base keeps the sign.
        configure(MODE_POLY, 1'b0, 32'h7FFF_FFFF, 32'sd65536, 32'sd0, 32'sd196608);
        send_pixel(-32'sd131072);
        send_pixel(32'sd98304);

        // Fractional power of a negative base is undefined.
        configure(MODE_POLY, 1'b0, 32'sd0, 32'sd65536, 32'sd0, 32'sd32768);
        send_pixel(-32'sd262144);
        send_pixel(32'sd262144);

        // Negative power of a zero base is undefined.
        configure(MODE_POLY, 1'b0, 32'sd0, 32'sd65536, 32'sd0, -32'sd65536);
        send_pixel(32'sd0);
        send_pixel(32'sd131072);

        // Zero power gives 1.0 for any base.
        configure(MODE_POLY, 1'b0, 32'sd0, 32'sd65536, 32'sd0, 32'sd0);
        send_pixel(-32'sd196608);
        send_pixel(32'sd0);

        configure(MODE_PASS, 1'b1, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'sd0);
        send_pixel(32'h8000_0000);
        send_pixel(32'sd12345);

        // Symmetric sigmoid, including a zero pixel.
        configure(MODE_SYM, 1'b0, 32'sd0, 32'sd65536, 32'sd0, 32'sd131072);
        send_pixel(32'sd0);
        send_pixel(32'sd65536);
        send_pixel(-32'sd65536);

        configure(MODE_STD, 1'b0, 32'sd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
        send_pixel(32'sd65536);
        send_pixel(-32'sd65536);

        // Random settings, each followed by a batch of random pixels; the last batch runs
        // with no idling on either side.
        for (int ph = 0; ph < 14; ph++)
        begin
            configure(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), rand_q(8 << 16),
                      ($urandom_range(0, 2) == 0) ? 32'sd65536 : rand_q(4 << 16),
                      rand_q(4 << 16), rand_power());
            if (ph == 13)
            begin
                quiet = 1'b1;
            end
            for (int i = 0; i < 50; i++)
            begin
                send_pixel(rand_q(16 << 16));
            end
        end

        src_valid <= 1'b0;
        while (sb.pending_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN) @(posedge clk);

        $display("Covered %0d settings across all four modes: %0d pixels sent, %0d checked.",
                 phases + 1, beats_in, beats_out);
        if (sb.errors == 0 && sb.pending_q.size() == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("%0d mismatches, %0d results missing", sb.errors, sb.pending_q.size());
            $display("status: fail");
        end
        $finish;
    end

endmodule
